>>> hdl/ray_box_slab_intersection_macros.svh
// Assertion macros for the ray and box slab intersection block.
// Included by the top level; it uses the clk and rst_n of that module.
`ifndef RAY_BOX_SLAB_INTERSECTION_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECTION_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define RBSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define RBSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/rbsi_pkg.sv
// Shared widths, constants and types of the ray and box slab intersection block.
// Used by the square root unit, the divider and the top level.
`default_nettype none

package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 33;
  localparam int SQ_W      = 64;
  localparam int LEN_W     = 32;
  localparam int SCALE_W   = 20;
  localparam int PP_W      = LEN_W + SCALE_W;
  localparam int QUO_W     = 41;
  localparam int T_W       = 42;
  localparam int DIST_W    = 31;
  localparam int SQRT_STG  = 32;
  localparam int DIV_STG   = 40;

  localparam logic [LEN_W-1:0]   LEN_EPS   = LEN_W'(((1 << FRAC_BITS) + 9999) / 10000);
  localparam logic [SCALE_W-1:0] PAR_SCALE = SCALE_W'(1000000);
  localparam logic [DIST_W-1:0]  MAXD_RST  = DIST_W'(5 << FRAC_BITS);

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef struct packed {
    logic [2:0][LEN_W-1:0] dmag;
    logic [2:0][LEN_W-1:0] mlo;
    logic [2:0][LEN_W-1:0] mhi;
    logic [2:0]            dneg;
    logic [2:0]            nlo;
    logic [2:0]            nhi;
    logic [2:0]            outf;
    logic [2:0][PP_W-1:0]  ppr;
  } sba_t;

  typedef struct packed {
    logic [2:0] outf;
    logic [2:0] par;
    logic [2:0] nt1;
    logic [2:0] nt2;
    logic       len_short;
  } sbb_t;

endpackage

`default_nettype wire

>>> hdl/ray_box_slab_intersection.sv
// Top level of the ray and box slab intersection block: the pipeline and its control.
// Depends on rbsi_pkg, rbsi_sqrt, rbsi_div and ray_box_slab_intersection_macros.svh.
//
//   channel  ports                         direction  handshake
//   in       in_origin_*, in_dir_*, in_box_* input     in_valid / in_ready
//   out      out_hit, out_hit_distance, ...  output    out_valid / out_ready
//   cfg      cfg_wr_data (max_distance)      input     cfg_wr_en, no wait
//
// One transaction enters per cycle while in_ready is high.
// The 82 register stages are set by the 32-stage square root and the 40-stage dividers.
// A stalled output lets bubbles close up; in_ready falls only when every stage is full.
// Reset clears all valid bits and sets max_distance to 5.0.
`default_nettype none
`include "ray_box_slab_intersection_macros.svh"

module ray_box_slab_intersection import rbsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_origin_x,
  input  logic signed [31:0]   in_origin_y,
  input  logic signed [31:0]   in_origin_z,
  input  logic signed [31:0]   in_dir_x,
  input  logic signed [31:0]   in_dir_y,
  input  logic signed [31:0]   in_dir_z,
  input  logic signed [31:0]   in_box_min_x,
  input  logic signed [31:0]   in_box_min_y,
  input  logic signed [31:0]   in_box_min_z,
  input  logic signed [31:0]   in_box_max_x,
  input  logic signed [31:0]   in_box_max_y,
  input  logic signed [31:0]   in_box_max_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [DIST_W-1:0]    out_hit_distance,
  output logic [1:0]           out_face_axis,
  output logic                 out_face_negative,
  input  logic                 cfg_wr_en,
  input  logic [DIST_W-1:0]    cfg_wr_data
);

  localparam int S_IN  = 1;
  localparam int S_MUL = 2;
  localparam int S_SUM = 3;
  localparam int S_SQ0 = 4;
  localparam int S_NUM = S_SQ0 + SQRT_STG;
  localparam int S_DV0 = S_NUM + 1;
  localparam int S_SGN = S_DV0 + DIV_STG;
  localparam int S_SWP = S_SGN + 1;
  localparam int S_AX0 = S_SWP + 1;
  localparam int NSTG  = S_AX0 + 3;

  logic [NSTG:1] vld_r, vld_in, adv;
  logic [DIST_W-1:0] maxd_r;

  logic [2:0][COORD_W-1:0] org, dir, bmin, bmax;

  logic [2:0][COORD_W-1:0] dmag1_r;
  logic [2:0]              dneg1_r;
  logic [2:0][DIFF_W-1:0]  dlo1_r, dhi1_r;

  logic [2:0][SQ_W-1:0] sq2_r;
  logic [SQ_W-1:0]      sum3_r;
  sba_t                 sba_r [S_MUL:S_NUM-1];
  logic [LEN_W-1:0]     root;

  logic [2:0][SQ_W-1:0]  nlo_r, nhi_r;
  logic [2:0][LEN_W-1:0] den_r;
  sbb_t                  sbb_r [S_NUM:NSTG-1];
  logic [2:0][QUO_W-1:0] quo_lo, quo_hi;

  logic signed [T_W-1:0] t1_r [3];
  logic signed [T_W-1:0] t2_r [3];
  logic signed [T_W-1:0] tlo_r [3][S_SWP:S_AX0+1];
  logic signed [T_W-1:0] thi_r [3][S_SWP:S_AX0+1];
  logic [2:0]            nf_r [S_SWP:S_AX0+1];

  logic                  ok_r [S_AX0:NSTG-1];
  logic signed [T_W-1:0] tn_r [S_AX0:NSTG-1];
  logic signed [T_W-1:0] tf_r [S_AX0:NSTG-1];
  axis_t                 ax_r [S_AX0:NSTG-1];
  logic                  ng_r [S_AX0:NSTG-1];

  logic              out_hit_r, out_neg_r;
  logic [DIST_W-1:0] out_dist_r;
  axis_t             out_axis_r;
  logic              hit_nxt;

  assign org  = {in_origin_z, in_origin_y, in_origin_x};
  assign dir  = {in_dir_z, in_dir_y, in_dir_x};
  assign bmin = {in_box_min_z, in_box_min_y, in_box_min_x};
  assign bmax = {in_box_max_z, in_box_max_y, in_box_max_x};

  // Valid bits and per-stage advance.
  assign vld_in = {vld_r[NSTG-1:1], in_valid};

  genvar k;
  generate
    for (k = 1; k <= NSTG; k++) begin : g_adv
      assign adv[k] = out_ready | ~(&vld_r[NSTG:k]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 1; s <= NSTG; s++) begin
        if (adv[s]) vld_r[s] <= vld_in[s];
      end
    end
  end

  assign in_ready = adv[S_IN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxd_r <= MAXD_RST;
    end else if (cfg_wr_en) begin
      maxd_r <= cfg_wr_data;
    end
  end

  // Input stage: direction magnitude and box offsets.
  always_ff @(posedge clk) begin
    if (adv[S_IN]) begin
      for (int i = 0; i < 3; i++) begin
        dneg1_r[i] <= dir[i][COORD_W-1];
        dmag1_r[i] <= dir[i][COORD_W-1] ? (COORD_W'(0) - dir[i]) : dir[i];
        dlo1_r[i]  <= {bmin[i][COORD_W-1], bmin[i]} - {org[i][COORD_W-1], org[i]};
        dhi1_r[i]  <= {bmax[i][COORD_W-1], bmax[i]} - {org[i][COORD_W-1], org[i]};
      end
    end
  end

  // Squares, parallel-test products, offset magnitudes, and the delay line.
  always_ff @(posedge clk) begin
    if (adv[S_MUL]) begin
      for (int i = 0; i < 3; i++) begin
        sq2_r[i]             <= SQ_W'(dmag1_r[i]) * SQ_W'(dmag1_r[i]);
        sba_r[S_MUL].ppr[i]  <= PP_W'(dmag1_r[i]) * PP_W'(PAR_SCALE);
        sba_r[S_MUL].dmag[i] <= dmag1_r[i];
        sba_r[S_MUL].dneg[i] <= dneg1_r[i];
        sba_r[S_MUL].nlo[i]  <= dlo1_r[i][DIFF_W-1];
        sba_r[S_MUL].nhi[i]  <= dhi1_r[i][DIFF_W-1];
        sba_r[S_MUL].mlo[i]  <= dlo1_r[i][DIFF_W-1] ? LEN_W'(DIFF_W'(0) - dlo1_r[i])
                                                     : dlo1_r[i][LEN_W-1:0];
        sba_r[S_MUL].mhi[i]  <= dhi1_r[i][DIFF_W-1] ? LEN_W'(DIFF_W'(0) - dhi1_r[i])
                                                     : dhi1_r[i][LEN_W-1:0];
        sba_r[S_MUL].outf[i] <= (!dlo1_r[i][DIFF_W-1] && (|dlo1_r[i])) ||
                                dhi1_r[i][DIFF_W-1];
      end
    end
    for (int s = S_SUM; s < S_NUM; s++) begin
      if (adv[s]) sba_r[s] <= sba_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[S_SUM]) begin
      sum3_r <= sq2_r[0] + sq2_r[1] + sq2_r[2];
    end
  end

  rbsi_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv[S_NUM-1:S_SQ0]),
    .rad  (sum3_r),
    .root (root)
  );

  // Length known: numerators, parallel flags and short-length flag.
  always_ff @(posedge clk) begin
    if (adv[S_NUM]) begin
      for (int i = 0; i < 3; i++) begin
        nlo_r[i] <= SQ_W'(sba_r[S_NUM-1].mlo[i]) * SQ_W'(root);
        nhi_r[i] <= SQ_W'(sba_r[S_NUM-1].mhi[i]) * SQ_W'(root);
        den_r[i] <= sba_r[S_NUM-1].dmag[i];
        sbb_r[S_NUM].par[i] <= sba_r[S_NUM-1].ppr[i] < PP_W'(root);
        sbb_r[S_NUM].nt1[i] <= sba_r[S_NUM-1].nlo[i] ^ sba_r[S_NUM-1].dneg[i];
        sbb_r[S_NUM].nt2[i] <= sba_r[S_NUM-1].nhi[i] ^ sba_r[S_NUM-1].dneg[i];
      end
      sbb_r[S_NUM].outf      <= sba_r[S_NUM-1].outf;
      sbb_r[S_NUM].len_short <= root < LEN_EPS;
    end
    for (int s = S_NUM + 1; s < NSTG; s++) begin
      if (adv[s]) sbb_r[s] <= sbb_r[s-1];
    end
  end

  genvar a;
  generate
    for (a = 0; a < 3; a++) begin : g_div
      rbsi_div u_div_lo (
        .clk (clk),
        .en  (adv[S_SGN-1:S_DV0]),
        .num (nlo_r[a]),
        .den (den_r[a]),
        .quo (quo_lo[a])
      );
      rbsi_div u_div_hi (
        .clk (clk),
        .en  (adv[S_SGN-1:S_DV0]),
        .num (nhi_r[a]),
        .den (den_r[a]),
        .quo (quo_hi[a])
      );
    end
  endgenerate

  // Signs applied, then the slab ends put in order.
  always_ff @(posedge clk) begin
    if (adv[S_SGN]) begin
      for (int i = 0; i < 3; i++) begin
        t1_r[i] <= sbb_r[S_SGN-1].nt1[i] ? (T_W'(0) - T_W'(quo_lo[i])) : T_W'(quo_lo[i]);
        t2_r[i] <= sbb_r[S_SGN-1].nt2[i] ? (T_W'(0) - T_W'(quo_hi[i])) : T_W'(quo_hi[i]);
      end
    end
    if (adv[S_SWP]) begin
      for (int i = 0; i < 3; i++) begin
        if (t1_r[i] > t2_r[i]) begin
          tlo_r[i][S_SWP] <= t2_r[i];
          thi_r[i][S_SWP] <= t1_r[i];
          nf_r[S_SWP][i]  <= 1'b0;
        end else begin
          tlo_r[i][S_SWP] <= t1_r[i];
          thi_r[i][S_SWP] <= t2_r[i];
          nf_r[S_SWP][i]  <= 1'b1;
        end
      end
    end
    for (int s = S_SWP + 1; s <= S_AX0 + 1; s++) begin
      if (adv[s]) begin
        for (int i = 0; i < 3; i++) begin
          tlo_r[i][s] <= tlo_r[i][s-1];
          thi_r[i][s] <= thi_r[i][s-1];
        end
        nf_r[s] <= nf_r[s-1];
      end
    end
  end

  // One axis per stage, in x, y, z order.
  generate
    for (a = 0; a < 3; a++) begin : g_axis
      localparam int S = S_AX0 + a;
      logic                  ok_in, ok_nxt, ng_in, ng_nxt;
      logic signed [T_W-1:0] tn_in, tn_nxt, tf_in, tf_nxt;
      axis_t                 ax_in, ax_nxt;

      if (a == 0) begin : g_first
        assign ok_in = !sbb_r[S-1].len_short;
        assign tn_in = '0;
        assign tf_in = T_W'(maxd_r);
        assign ax_in = AXIS_NONE;
        assign ng_in = 1'b0;
      end else begin : g_next
        assign ok_in = ok_r[S-1];
        assign tn_in = tn_r[S-1];
        assign tf_in = tf_r[S-1];
        assign ax_in = ax_r[S-1];
        assign ng_in = ng_r[S-1];
      end

      always_comb begin
        ok_nxt = ok_in;
        tn_nxt = tn_in;
        tf_nxt = tf_in;
        ax_nxt = ax_in;
        ng_nxt = ng_in;
        if (sbb_r[S-1].par[a]) begin
          if (sbb_r[S-1].outf[a]) ok_nxt = 1'b0;
        end else begin
          if (tlo_r[a][S-1] > tn_in) begin
            tn_nxt = tlo_r[a][S-1];
            ax_nxt = axis_t'(2'(a));
            ng_nxt = nf_r[S-1][a];
          end
          if (thi_r[a][S-1] < tf_in) tf_nxt = thi_r[a][S-1];
          if (tn_nxt > tf_nxt) ok_nxt = 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (adv[S]) begin
          ok_r[S] <= ok_nxt;
          tn_r[S] <= tn_nxt;
          tf_r[S] <= tf_nxt;
          ax_r[S] <= ax_nxt;
          ng_r[S] <= ng_nxt;
        end
      end
    end
  endgenerate

  // Output register.
  assign hit_nxt = ok_r[NSTG-1] && (tn_r[NSTG-1] >= 0) &&
                   (tn_r[NSTG-1] <= $signed(T_W'(maxd_r)));

  always_ff @(posedge clk) begin
    if (adv[NSTG]) begin
      out_hit_r  <= hit_nxt;
      out_dist_r <= hit_nxt ? tn_r[NSTG-1][DIST_W-1:0] : '0;
      out_axis_r <= hit_nxt ? ax_r[NSTG-1] : AXIS_NONE;
      out_neg_r  <= hit_nxt && ng_r[NSTG-1];
    end
  end

  assign out_valid         = vld_r[NSTG];
  assign out_hit           = out_hit_r;
  assign out_hit_distance  = out_dist_r;
  assign out_face_axis     = out_axis_r;
  assign out_face_negative = out_neg_r;

  `RBSI_ASSERT(a_miss_clean,
    !out_valid || out_hit ||
    (out_face_axis == AXIS_NONE && out_hit_distance == '0 && !out_face_negative),
    "miss result carries face or distance")
  `RBSI_ASSERT(a_hit_in_range, !out_valid || !out_hit || out_hit_distance <= maxd_r,
    "hit distance beyond max_distance")
  `RBSI_ASSERT(a_inside_zero,
    !out_valid || !out_hit || out_face_axis != AXIS_NONE || out_hit_distance == '0,
    "hit without a face has nonzero distance")
  `RBSI_ASSERT(a_full_on_stall, in_ready || ((&vld_r) && !out_ready),
    "input stalled while the pipeline has a bubble")
  `RBSI_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_r[S_IN],
    "accepted transaction did not enter the pipeline")

endmodule

`default_nettype wire

>>> hdl/rbsi_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on rbsi_pkg for widths and the stage count.
`default_nettype none

module rbsi_sqrt import rbsi_pkg::*; (
  input  logic                clk,
  input  logic [SQRT_STG-1:0] en,
  input  logic [SQ_W-1:0]     rad,
  output logic [LEN_W-1:0]    root
);

  logic [SQ_W-1:0] x_r [SQRT_STG];
  logic [SQ_W-1:0] r_r [SQRT_STG];

  genvar j;
  generate
    for (j = 0; j < SQRT_STG; j++) begin : g_stg
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STG - 1 - j));
      logic [SQ_W-1:0] x_in, r_in, x_nxt, r_nxt, trial;

      if (j == 0) begin : g_first
        assign x_in = rad;
        assign r_in = '0;
      end else begin : g_next
        assign x_in = x_r[j-1];
        assign r_in = r_r[j-1];
      end

      always_comb begin
        trial = r_in + BIT;
        if (x_in >= trial) begin
          x_nxt = x_in - trial;
          r_nxt = (r_in >> 1) + BIT;
        end else begin
          x_nxt = x_in;
          r_nxt = r_in >> 1;
        end
      end

      always_ff @(posedge clk) begin
        if (en[j]) begin
          x_r[j] <= x_nxt;
          r_r[j] <= r_nxt;
        end
      end
    end
  endgenerate

  assign root = r_r[SQRT_STG-1][LEN_W-1:0];

endmodule

`default_nettype wire

>>> hdl/rbsi_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating at 2^40.
// Depends on rbsi_pkg for widths and the stage count.
`default_nettype none

module rbsi_div import rbsi_pkg::*; (
  input  logic               clk,
  input  logic [DIV_STG-1:0] en,
  input  logic [SQ_W-1:0]    num,
  input  logic [LEN_W-1:0]   den,
  output logic [QUO_W-1:0]   quo
);

  logic [LEN_W-1:0]   rem_r [DIV_STG];
  logic [LEN_W-1:0]   den_r [DIV_STG];
  logic [DIV_STG-1:0] low_r [DIV_STG];
  logic [DIV_STG-1:0] quo_r [DIV_STG];
  logic [DIV_STG-1:0] sat_r;

  genvar j;
  generate
    for (j = 0; j < DIV_STG; j++) begin : g_stg
      logic [LEN_W-1:0]   rem_in, den_in, shifted, rem_nxt;
      logic [DIV_STG-1:0] low_in, quo_in;
      logic               sat_in, qbit;

      if (j == 0) begin : g_first
        assign rem_in = LEN_W'(num[SQ_W-1:DIV_STG]);
        assign low_in = num[DIV_STG-1:0];
        assign den_in = den;
        assign quo_in = '0;
        assign sat_in = LEN_W'(num[SQ_W-1:DIV_STG]) >= den;
      end else begin : g_next
        assign rem_in = rem_r[j-1];
        assign low_in = low_r[j-1];
        assign den_in = den_r[j-1];
        assign quo_in = quo_r[j-1];
        assign sat_in = sat_r[j-1];
      end

      always_comb begin
        shifted = {rem_in[LEN_W-2:0], low_in[DIV_STG-1]};
        qbit    = shifted >= den_in;
        rem_nxt = qbit ? (shifted - den_in) : shifted;
      end

      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem_r[j] <= rem_nxt;
          den_r[j] <= den_in;
          low_r[j] <= low_in << 1;
          quo_r[j] <= {quo_in[DIV_STG-2:0], qbit};
          sat_r[j] <= sat_in;
        end
      end
    end
  endgenerate

  assign quo = sat_r[DIV_STG-1] ? (QUO_W'(1) << DIV_STG)
                                : {{(QUO_W-DIV_STG){1'b0}}, quo_r[DIV_STG-1]};

endmodule

`default_nettype wire

>>> sim/tb_ray_box_slab_intersection.sv
// Testbench for ray_box_slab_intersection: directed rays from a table, then random rays,
// each result checked against the table's value or a fixed-point slab test predictor
// kept in this file. Depends on rbsi_pkg and the RTL of the block only.
`default_nettype none

module tb_ray_box_slab_intersection import rbsi_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 65536;
  localparam int CYCLE_LIMIT = 600000;
  localparam longint unsigned T_LIMIT = 64'd1 << 40;
  localparam longint unsigned NEAR_PAR = 64'd1000000;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
    logic [2:0][31:0] bmin;
    logic [2:0][31:0] bmax;
  } ray_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
    axis_t             axis;
    logic              neg;
  } hit_t;

  typedef struct {
    ray_t r;
    bit   typed;
    hit_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ray_t in_ray = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [DIST_W-1:0] out_hit_distance;
  logic [1:0] out_face_axis;
  logic out_face_negative;
  logic cfg_wr_en = 1'b0;
  logic [DIST_W-1:0] cfg_wr_data = '0;

  hit_t pending_hits[$];
  logic [DIST_W-1:0] max_dist = MAXD_RST;
  int errors = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  row_t rows[$];

  const hit_t MISS = '{hit: 1'b0, distance: '0, axis: AXIS_NONE, neg: 1'b0};
  const axis_t AXIS_OF[3] = '{AXIS_X, AXIS_Y, AXIS_Z};

  ray_box_slab_intersection dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_origin_x(in_ray.org[0]), .in_origin_y(in_ray.org[1]), .in_origin_z(in_ray.org[2]),
    .in_dir_x(in_ray.dir[0]), .in_dir_y(in_ray.dir[1]), .in_dir_z(in_ray.dir[2]),
    .in_box_min_x(in_ray.bmin[0]), .in_box_min_y(in_ray.bmin[1]),
    .in_box_min_z(in_ray.bmin[2]),
    .in_box_max_x(in_ray.bmax[0]), .in_box_max_y(in_ray.bmax[1]),
    .in_box_max_z(in_ray.bmax[2]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_hit_distance(out_hit_distance),
    .out_face_axis(out_face_axis), .out_face_negative(out_face_negative),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ray_box_slab_intersection failed");
      $finish;
    end
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Distance to one slab plane along the normalized ray, truncated and saturated.
  function automatic longint plane_t(longint diff, longint unsigned len, longint d);
    longint unsigned dm;
    longint unsigned q;
    dm = mag(d);
    if (dm == 0) return 0;
    q = (mag(diff) * len) / dm;
    if (q > T_LIMIT) q = T_LIMIT;
    return ((diff < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic hit_t predict_hit(ray_t r, logic [DIST_W-1:0] maxd);
    longint o, d, lo, hi, t1, t2, tmp, t_near, t_far;
    longint unsigned sq, len;
    bit ok, n1, neg;
    axis_t ax;
    hit_t res;
    sq = 0;
    for (int i = 0; i < 3; i++) sq += mag(signed'(r.dir[i])) * mag(signed'(r.dir[i]));
    len = int_sqrt(sq);
    ok = len >= LEN_EPS;
    t_near = 0;
    t_far = longint'(maxd);
    ax = AXIS_NONE;
    neg = 1'b0;
    for (int i = 0; i < 3 && ok; i++) begin
      o = signed'(r.org[i]);
      d = signed'(r.dir[i]);
      lo = signed'(r.bmin[i]);
      hi = signed'(r.bmax[i]);
      if (mag(d) * NEAR_PAR < len) begin
        if (o < lo || o > hi) ok = 1'b0;
      end else begin
        t1 = plane_t(lo - o, len, d);
        t2 = plane_t(hi - o, len, d);
        n1 = 1'b1;
        if (t1 > t2) begin
          tmp = t1;
          t1 = t2;
          t2 = tmp;
          n1 = 1'b0;
        end
        if (t1 > t_near) begin
          t_near = t1;
          ax = AXIS_OF[i];
          neg = n1;
        end
        if (t2 < t_far) t_far = t2;
        if (t_near > t_far) ok = 1'b0;
      end
    end
    if (ok && (t_near < 0 || t_near > longint'(maxd))) ok = 1'b0;
    if (!ok) return MISS;
    res.hit = 1'b1;
    res.distance = t_near[DIST_W-1:0];
    res.axis = ax;
    res.neg = neg;
    return res;
  endfunction

  function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                  int lx, int ly, int lz, int hx, int hy, int hz);
    ray_t r;
    r.org = {oz, oy, ox};
    r.dir = {dz, dy, dx};
    r.bmin = {lz, ly, lx};
    r.bmax = {hz, hy, hx};
    return r;
  endfunction

  function automatic int rand_span(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    int c, h, o, t;
    if ($urandom_range(99) < 20) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      c = rand_span(8 * ONE);
      h = int'($urandom_range(3 * ONE, ONE / 8));
      o = rand_span(10 * ONE);
      t = c - o + rand_span(2 * ONE);
      if ($urandom_range(9) == 0) t = 0;
      else if ($urandom_range(9) == 0) t = rand_span(20);
      r.org[i] = o;
      r.dir[i] = t;
      r.bmin[i] = ($urandom_range(9) == 0) ? c + h : c - h;
      r.bmax[i] = ($urandom_range(9) == 0) ? c - h : c + h;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_ray(ray_t r, bit typed, hit_t want);
    bit rdy;
    in_valid <= 1'b1;
    in_ray <= r;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    pending_hits.insert(pending_hits.size(), typed ? want : predict_hit(r, max_dist));
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_max_dist(logic [DIST_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_dist = v;
  endtask

  task automatic send_random(int n);
    for (int k = 0; k < n; k++) send_ray(random_ray(), 1'b0, MISS);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= no_idle || $urandom_range(99) >= 35;
    end
  end

  initial begin
    hit_t want;
    forever begin
      @(negedge clk);
      if (out_valid && out_ready) begin
        if (pending_hits.size() == 0) begin
          report_mismatch("unexpected result transaction", 1, 0);
        end else begin
          want = pending_hits.pop_front();
          if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
          if (out_hit_distance !== want.distance)
            report_mismatch("hit_distance", out_hit_distance, want.distance);
          if (out_face_axis !== want.axis)
            report_mismatch("face_axis", out_face_axis, want.axis);
          if (out_face_negative !== want.neg)
            report_mismatch("face_negative", out_face_negative, want.neg);
        end
      end
    end
  end

  initial begin
    rows.insert(rows.size(),
      '{mk_ray(0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE), 1, MISS});
    rows.insert(rows.size(),
      '{mk_ray(0, 0, 0, 1, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE), 1, MISS});
    rows.insert(rows.size(),
      '{mk_ray(0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE), 1,
        '{1'b1, 31'd0, AXIS_NONE, 1'b0}});
    rows.insert(rows.size(),
      '{mk_ray(0, 0, 0, ONE, 0, 0, 2*ONE, -ONE, -ONE, 3*ONE, ONE, ONE), 1,
        '{1'b1, 31'd131072, AXIS_X, 1'b1}});
    rows.insert(rows.size(),
      '{mk_ray(5*ONE, 0, 0, -ONE, 0, 0, 2*ONE, -ONE, -ONE, 3*ONE, ONE, ONE), 1,
        '{1'b1, 31'd131072, AXIS_X, 1'b0}});
    rows.insert(rows.size(),
      '{mk_ray(0, 0, 0, 0, ONE, 0, -ONE, ONE, -ONE, ONE, 4*ONE, ONE), 1,
        '{1'b1, 31'd65536, AXIS_Y, 1'b1}});
    rows.insert(rows.size(),
      '{mk_ray(0, 0, 3*ONE, 0, 0, -2*ONE, -ONE, -ONE, -2*ONE, ONE, ONE, ONE), 1,
        '{1'b1, 31'd131072, AXIS_Z, 1'b0}});
    rows.insert(rows.size(),
      '{mk_ray(0, 0, 0, ONE, 0, 0, 10*ONE, -ONE, -ONE, 11*ONE, ONE, ONE), 1, MISS});
    rows.insert(rows.size(),
      '{mk_ray(0, 5*ONE, 0, ONE, 0, 0, 2*ONE, -ONE, -ONE, 3*ONE, ONE, ONE), 1, MISS});
    rows.insert(rows.size(),
      '{mk_ray(0, 0, 0, ONE, 0, 0, -3*ONE, -ONE, -ONE, -2*ONE, ONE, ONE), 1, MISS});
    rows.insert(rows.size(),
      '{mk_ray(0, 0, 0, ONE, ONE, 0, 3*ONE, 2*ONE, -ONE, 2*ONE, 3*ONE, ONE), 0, MISS});
    rows.insert(rows.size(),
      '{mk_ray(0, 0, 0, 7, 0, 0, 2*ONE, -ONE, -ONE, 32'h7fffffff, ONE, ONE), 0, MISS});
    rows.insert(rows.size(), '{ray_t'({12{32'h7fffffff}}), 0, MISS});
    rows.insert(rows.size(), '{ray_t'({12{32'h80000000}}), 0, MISS});
    rows.insert(rows.size(), '{ray_t'({6{32'h80000000, 32'h7fffffff}}), 0, MISS});
    rows.insert(rows.size(), '{ray_t'({6{32'h55555555, 32'haaaaaaaa}}), 0, MISS});
    rows.insert(rows.size(),
      '{mk_ray(0, 0, 0, 32'h80000000, 32'h7fffffff, 1, -ONE, -ONE, -ONE,
               ONE, ONE, ONE), 0, MISS});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[k]) send_ray(rows[k].r, rows[k].typed, rows[k].want);

    write_max_dist('0);
    send_random(250);
    write_max_dist({DIST_W{1'b1}});
    no_idle = 1'b1;
    hold_req = 1'b1;
    send_random(300);
    no_idle = 1'b0;
    write_max_dist(DIST_W'($urandom));
    send_random(300);
    write_max_dist(DIST_W'(20 * ONE));
    send_random(250);
    drain();
    send_random(300);
    drain();

    if (errors == 0) begin
      $display("tb_ray_box_slab_intersection passed");
    end else begin
      $display("tb_ray_box_slab_intersection failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
